// ===== rtl/necir_pkg.sv =====
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types, constants and the window compare for the NEC IR decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  localparam int FRAME_BITS = 32;
  localparam int CNT_W      = $clog2(FRAME_BITS);
  localparam int NOM_W      = 16;
  localparam int TOL_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [NOM_W-1:0] START_NOM_RST  = 16'd12442;
  localparam logic [NOM_W-1:0] REPEAT_NOM_RST = 16'd10368;
  localparam logic [NOM_W-1:0] ZERO_NOM_RST   = 16'd1032;
  localparam logic [NOM_W-1:0] ONE_NOM_RST    = 16'd2073;
  localparam logic [TOL_W-1:0] TOL_RST        = 15'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_NOM  = 3'd0,
    REG_REPEAT_NOM = 3'd1,
    REG_ZERO_NOM   = 3'd2,
    REG_ONE_NOM    = 3'd3,
    REG_TOLERANCE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_FRAME  = 2'd1,
    EV_REPEAT = 2'd2,
    EV_BADCHK = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  // window hits of one edge interval
  typedef struct packed {
    logic in_start;
    logic in_repeat;
    logic in_zero;
    logic in_one;
  } win_t;

  typedef struct packed {
    logic [NOM_W-1:0] start_nom;
    logic [NOM_W-1:0] repeat_nom;
    logic [NOM_W-1:0] zero_nom;
    logic [NOM_W-1:0] one_nom;
    logic [TOL_W-1:0] tol;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   pop;
  } back_stat_t;

  // exclusive window: nom - tol < v < nom + tol, no wrap
  function automatic logic in_window(input logic [NOM_W-1:0] v,
                                     input logic [NOM_W-1:0] nom,
                                     input logic [TOL_W-1:0] tol);
    logic signed [NOM_W+1:0] lo;
    logic signed [NOM_W+1:0] hi;
    logic signed [NOM_W+1:0] vs;
    lo = $signed({2'b00, nom}) - $signed({3'b000, tol});
    hi = $signed({2'b00, nom}) + $signed({3'b000, tol});
    vs = $signed({2'b00, v});
    return (vs > lo) && (vs < hi);
  endfunction

endpackage

// ===== rtl/nec_ir_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC infrared remote decoder fed one falling-edge interval per word.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   in       | in_valid / in_ready   | interval[15:0]
//   out      | out_valid / out_ready | event_res[1:0], address, command
//   cfg      | cfg_wen               | cfg_index[2:0], cfg_wdata[15:0]
//
// One word per cycle while the output is not stalled; a result passes the
// compare register, loaded at acceptance, then the two-entry queue, then the
// result register.
// Synchronous reset clears sequencing state, queue and latched bytes and
// loads the default window settings.
// A stalled output backs up into the queue and then the compare stage; the
// front keeps taking words until both are full.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] interval,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_res,
  output logic [7:0]  address,
  output logic [7:0]  command,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import necir_pkg::*;

  cfg_t              cfg;
  logic              f_valid;
  win_t              f_word;
  logic              q_ready;
  logic              q_valid;
  win_t              q_word;
  logic              pop;
  logic [QCNT_W-1:0] q_count;
  back_stat_t        stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_nom  <= START_NOM_RST;
      cfg.repeat_nom <= REPEAT_NOM_RST;
      cfg.zero_nom   <= ZERO_NOM_RST;
      cfg.one_nom    <= ONE_NOM_RST;
      cfg.tol        <= TOL_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_START_NOM:  cfg.start_nom  <= cfg_wdata;
        REG_REPEAT_NOM: cfg.repeat_nom <= cfg_wdata;
        REG_ZERO_NOM:   cfg.zero_nom   <= cfg_wdata;
        REG_ONE_NOM:    cfg.one_nom    <= cfg_wdata;
        REG_TOLERANCE:  cfg.tol        <= cfg_wdata[TOL_W-1:0];
        default:        cfg.tol        <= cfg.tol;
      endcase
    end
  end

  necir_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .interval (interval),
    .f_valid  (f_valid),
    .f_word   (f_word),
    .q_ready  (q_ready)
  );

  necir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && q_ready),
    .push_word (f_word),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .count     (q_count)
  );

  necir_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .address   (address),
    .command   (command),
    .stat      (stat)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("queue count past depth");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> (!out_valid || out_ready))
    else $error("word popped into an occupied result slot");

  a_idle_arms: assert property (@(posedge clk) disable iff (rst)
    (stat.pop && stat.phase == PH_IDLE) |=> stat.phase == PH_ARMED)
    else $error("idle edge did not arm the decoder");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> q_count != '0)
    else $error("pop from an empty queue");

endmodule

// ===== rtl/necir_classify.sv =====
// ----------------------------------------------------------------------------
// necir_classify
// Front end: accepts an edge interval and registers its window hits.
// ----------------------------------------------------------------------------
module necir_classify (
  input  logic                      clk,
  input  logic                      rst,
  input  necir_pkg::cfg_t           cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [necir_pkg::NOM_W-1:0] interval,
  output logic                      f_valid,
  output necir_pkg::win_t           f_word,
  input  logic                      q_ready
);
  import necir_pkg::*;

  logic accept;
  win_t hits;

  assign in_ready = !f_valid || q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hits.in_start  = in_window(interval, cfg.start_nom,  cfg.tol);
    hits.in_repeat = in_window(interval, cfg.repeat_nom, cfg.tol);
    hits.in_zero   = in_window(interval, cfg.zero_nom,   cfg.tol);
    hits.in_one    = in_window(interval, cfg.one_nom,    cfg.tol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_word <= hits;
    end
  end

endmodule

// ===== rtl/necir_queue.sv =====
// ----------------------------------------------------------------------------
// necir_queue
// Short queue of classified words between front end and frame engine.
// ----------------------------------------------------------------------------
module necir_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  necir_pkg::win_t             push_word,
  output logic                        q_ready,
  input  logic                        pop,
  output logic                        q_valid,
  output necir_pkg::win_t             q_word,
  output logic [necir_pkg::QCNT_W-1:0] count
);
  import necir_pkg::*;

  win_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign q_ready = (count != QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

// ===== rtl/necir_frame.sv =====
// ----------------------------------------------------------------------------
// necir_frame
// Back end: leader/bit sequencing, complement check and result register.
// ----------------------------------------------------------------------------
module necir_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  necir_pkg::win_t        q_word,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             event_res,
  output logic [7:0]             address,
  output logic [7:0]             command,
  output necir_pkg::back_stat_t  stat
);
  import necir_pkg::*;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [CNT_W-1:0]       bit_count;
  logic [CNT_W-1:0]       bit_count_next;
  logic [FRAME_BITS-1:0]  shift_data;
  logic [FRAME_BITS-1:0]  shift_data_next;
  logic [7:0]             last_address;
  logic [7:0]             last_command;
  logic                   bit_ok;
  logic                   frame_done;
  logic                   check_ok;
  event_t                 event_code;
  logic                   latch;

  assign pop  = q_valid && (!out_valid || out_ready);
  assign stat = '{phase: phase, pop: pop};

  assign bit_ok     = q_word.in_zero || q_word.in_one;
  assign frame_done = bit_ok && (bit_count == CNT_W'(FRAME_BITS - 1));
  // new bits enter at the top, so the first one ends up in bit 0
  assign check_ok = (shift_data_next[7:0]   == ~shift_data_next[15:8]) &&
                    (shift_data_next[23:16] == ~shift_data_next[31:24]);

  // next state
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_data_next = {!q_word.in_zero, shift_data[FRAME_BITS-1:1]};
    unique case (phase)
      PH_ARMED: begin
        bit_count_next = '0;
        if (q_word.in_start) begin
          phase_next = PH_DATA;
        end else if (q_word.in_repeat) begin
          phase_next = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (!bit_ok) begin
          phase_next      = PH_ARMED;
          bit_count_next  = '0;
          shift_data_next = '0;
        end else if (frame_done) begin
          phase_next     = PH_IDLE;
          bit_count_next = '0;
        end else begin
          bit_count_next = bit_count + 1'b1;
        end
      end
      default: begin
        phase_next = PH_ARMED;
      end
    endcase
  end

  // outputs
  always_comb begin
    event_code = EV_NONE;
    latch      = 1'b0;
    unique case (phase)
      PH_ARMED: begin
        if (!q_word.in_start && q_word.in_repeat) begin
          event_code = EV_REPEAT;
        end
      end
      PH_DATA: begin
        if (frame_done) begin
          event_code = check_ok ? EV_FRAME : EV_BADCHK;
          latch      = check_ok;
        end
      end
      default: begin
        event_code = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      shift_data   <= '0;
      last_address <= '0;
      last_command <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        phase      <= phase_next;
        bit_count  <= bit_count_next;
        if (phase == PH_DATA) begin
          shift_data <= shift_data_next;
        end
        if (latch) begin
          last_address <= shift_data_next[7:0];
          last_command <= shift_data_next[23:16];
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word: always carries the latched bytes
  always_ff @(posedge clk) begin
    if (pop) begin
      event_res <= event_code;
      address   <= latch ? shift_data_next[7:0]   : last_address;
      command   <= latch ? shift_data_next[23:16] : last_command;
    end
  end

endmodule
